>>> rtl/lrfb_pkg.sv
// ----------------------------------------------------------------------------
// lrfb_pkg
// Shared types and constants of the line rasterizer framebuffer.
// ----------------------------------------------------------------------------
package lrfb_pkg;

    localparam int COORD_W   = 10;
    localparam int COLOR_W   = 8;
    localparam int COUNT_W   = 10;
    localparam int ERR_W     = COORD_W + 4;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;
    localparam int REG_IDX_W = 2;

    localparam int FRAME_WIDTH_DEF  = 512;
    localparam int FRAME_HEIGHT_DEF = 512;

    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_LEFT   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TOP    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_BOTTOM = 2'd3;

    localparam logic [COORD_W-1:0] LEFT_RST   = 10'd0;
    localparam logic [COORD_W-1:0] TOP_RST    = 10'd0;
    localparam logic [COORD_W-1:0] RIGHT_RST  = 10'd512;
    localparam logic [COORD_W-1:0] BOTTOM_RST = 10'd512;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic   req_type;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        color_t pen_color;
    } req_t;

    typedef struct packed {
        color_t read_color;
        logic   line_drawn;
        count_t pixels_written;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW,
        ST_READ,
        ST_READ_DATA,
        ST_DONE
    } state_t;

endpackage

>>> rtl/lrfb_store.sv
// ----------------------------------------------------------------------------
// lrfb_store
// Framebuffer memory: one write port, one registered read port, and a
// zero-fill sweep after reset.
// ----------------------------------------------------------------------------
module lrfb_store #(
    parameter int DEPTH = lrfb_pkg::FRAME_WIDTH_DEF * lrfb_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  lrfb_pkg::color_t              wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output lrfb_pkg::color_t              rd_data,
    output logic                          busy
);

    localparam int AW = $clog2(DEPTH);

    lrfb_pkg::color_t mem [DEPTH];

    logic [AW-1:0]    clr_addr_reg;
    logic [AW-1:0]    clr_addr_next;
    logic             busy_reg;
    logic             busy_next;
    lrfb_pkg::color_t rd_data_reg;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    lrfb_pkg::color_t mem_wdata;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        mem_we    = busy_reg || wr_en;
        mem_waddr = busy_reg ? clr_addr_reg : wr_addr;
        mem_wdata = busy_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

>>> rtl/line_rasterizer_framebuffer_top.sv
// ----------------------------------------------------------------------------
// line_rasterizer_framebuffer_top
// Bresenham line engine and pixel read-back over an 8-bit indexed framebuffer.
// ----------------------------------------------------------------------------
// One request is worked at a time. A line walks max(|dx|,|dy|)+1 pixels, up
// to 1023, one pixel at a time, since the framebuffer has a single write port
// that takes one pixel a cycle; a line rejected by the viewport goes from idle
// straight to done; a read passes the read and read-data states. After reset
// all FRAME_WIDTH*FRAME_HEIGHT pixels (262144 by default) are swept to zero,
// with req_stall high; viewport registers can be written during the sweep.
// The response register lets the next request enter while a result waits.
module line_rasterizer_framebuffer_top #(
    parameter int FRAME_WIDTH  = lrfb_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = lrfb_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  lrfb_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output lrfb_pkg::rsp_t                rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lrfb_pkg::APB_AW-1:0]   paddr,
    input  logic [lrfb_pkg::APB_DW-1:0]   pwdata,
    output logic [lrfb_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW_W  = $clog2(FRAME_WIDTH + 1);
    localparam int MUL_W = lrfb_pkg::COORD_W + FW_W;
    localparam int EW    = lrfb_pkg::ERR_W;

    // viewport registers
    lrfb_pkg::coord_t left_reg, top_reg, right_reg, bottom_reg;
    logic cfg_wr;
    logic [lrfb_pkg::REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[lrfb_pkg::REG_IDX_W+1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= lrfb_pkg::LEFT_RST;
            top_reg    <= lrfb_pkg::TOP_RST;
            right_reg  <= lrfb_pkg::RIGHT_RST;
            bottom_reg <= lrfb_pkg::BOTTOM_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                lrfb_pkg::REG_LEFT:   left_reg   <= pwdata[lrfb_pkg::COORD_W-1:0];
                lrfb_pkg::REG_TOP:    top_reg    <= pwdata[lrfb_pkg::COORD_W-1:0];
                lrfb_pkg::REG_RIGHT:  right_reg  <= pwdata[lrfb_pkg::COORD_W-1:0];
                lrfb_pkg::REG_BOTTOM: bottom_reg <= pwdata[lrfb_pkg::COORD_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            lrfb_pkg::REG_LEFT:   prdata = lrfb_pkg::APB_DW'(left_reg);
            lrfb_pkg::REG_TOP:    prdata = lrfb_pkg::APB_DW'(top_reg);
            lrfb_pkg::REG_RIGHT:  prdata = lrfb_pkg::APB_DW'(right_reg);
            lrfb_pkg::REG_BOTTOM: prdata = lrfb_pkg::APB_DW'(bottom_reg);
            default:              prdata = '0;
        endcase
    end

    function automatic logic in_view(lrfb_pkg::coord_t x, lrfb_pkg::coord_t y);
        return (x >= left_reg) && (x < right_reg) && (y >= top_reg) && (y < bottom_reg);
    endfunction

    function automatic logic in_frame(lrfb_pkg::coord_t x, lrfb_pkg::coord_t y);
        return (int'(x) < FRAME_WIDTH) && (int'(y) < FRAME_HEIGHT);
    endfunction

    function automatic logic [AW-1:0] addr_of(lrfb_pkg::coord_t x, lrfb_pkg::coord_t y);
        logic [MUL_W-1:0] prod;
        prod = MUL_W'(y) * MUL_W'(FRAME_WIDTH);
        return AW'(prod + MUL_W'(x));
    endfunction

    // control
    lrfb_pkg::state_t state_reg, state_next;
    logic store_busy;
    logic req_take;
    logic slot_free;
    logic rsp_load;
    logic mem_rd_en;
    logic at_end;
    logic req_drawn;

    // datapath
    lrfb_pkg::coord_t x_reg, y_reg, xe_reg, ye_reg;
    lrfb_pkg::coord_t x_next, y_next, xe_next, ye_next;
    lrfb_pkg::color_t pen_reg, pen_next;
    logic signed [EW-1:0] dx_reg, dy_reg, err_reg;
    logic signed [EW-1:0] dx_next, dy_next, err_next;
    logic sx_reg, sy_reg, sx_next, sy_next;
    lrfb_pkg::count_t count_reg, count_next;
    logic drawn_reg, drawn_next;
    lrfb_pkg::color_t res_color_reg, res_color_next;
    logic rd_in_frame_reg, rd_in_frame_next;

    logic plot_we_reg, plot_we_next;
    logic [AW-1:0] plot_addr_reg, plot_addr_next;
    lrfb_pkg::color_t plot_data_reg, plot_data_next;

    logic rsp_valid_reg, rsp_valid_next;
    lrfb_pkg::rsp_t rsp_reg, rsp_next;

    lrfb_pkg::color_t mem_rd_data;
    lrfb_pkg::coord_t dx_mag, dy_mag;
    logic signed [EW-1:0] e2;
    logic step_x, step_y, plot;

    assign at_end    = (x_reg == xe_reg) && (y_reg == ye_reg);
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lrfb_pkg::ST_IDLE:
            begin
                if (req_valid && !store_busy)
                begin
                    if (req.req_type == lrfb_pkg::REQ_READ)
                    begin
                        state_next = lrfb_pkg::ST_READ;
                    end
                    else if (req_drawn)
                    begin
                        state_next = lrfb_pkg::ST_DRAW;
                    end
                    else
                    begin
                        state_next = lrfb_pkg::ST_DONE;
                    end
                end
            end
            lrfb_pkg::ST_DRAW:
            begin
                if (at_end)
                begin
                    state_next = lrfb_pkg::ST_DONE;
                end
            end
            lrfb_pkg::ST_READ:      state_next = lrfb_pkg::ST_READ_DATA;
            lrfb_pkg::ST_READ_DATA: state_next = lrfb_pkg::ST_DONE;
            lrfb_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = lrfb_pkg::ST_IDLE;
                end
            end
            default:                state_next = lrfb_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        req_stall = 1'b1;
        req_take  = 1'b0;
        mem_rd_en = 1'b0;
        rsp_load  = 1'b0;
        case (state_reg)
            lrfb_pkg::ST_IDLE:
            begin
                req_stall = store_busy;
                req_take  = req_valid && !store_busy;
            end
            lrfb_pkg::ST_READ: mem_rd_en = 1'b1;
            lrfb_pkg::ST_DONE: rsp_load  = slot_free;
            default:           ;
        endcase
    end

    // Bresenham step
    always_comb
    begin
        req_drawn = in_view(req.start_x, req.start_y) && in_view(req.end_x, req.end_y);
        e2        = err_reg <<< 1;
        step_x    = (e2 >= dy_reg);
        step_y    = (e2 <= dx_reg);
        plot      = in_view(x_reg, y_reg) && in_frame(x_reg, y_reg);
        dx_mag    = (req.end_x >= req.start_x) ? req.end_x - req.start_x
                                               : req.start_x - req.end_x;
        dy_mag    = (req.end_y >= req.start_y) ? req.end_y - req.start_y
                                               : req.start_y - req.end_y;
    end

    // datapath next values
    always_comb
    begin
        x_next           = x_reg;
        y_next           = y_reg;
        xe_next          = xe_reg;
        ye_next          = ye_reg;
        pen_next         = pen_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        err_next         = err_reg;
        sx_next          = sx_reg;
        sy_next          = sy_reg;
        count_next       = count_reg;
        drawn_next       = drawn_reg;
        res_color_next   = res_color_reg;
        rd_in_frame_next = rd_in_frame_reg;
        plot_we_next     = 1'b0;
        plot_addr_next   = plot_addr_reg;
        plot_data_next   = plot_data_reg;

        if (req_take)
        begin
            x_next           = req.start_x;
            y_next           = req.start_y;
            xe_next          = req.end_x;
            ye_next          = req.end_y;
            pen_next         = req.pen_color;
            dx_next          = EW'(dx_mag);
            dy_next          = -EW'(dy_mag);
            err_next         = EW'(dx_mag) - EW'(dy_mag);
            sx_next          = (req.start_x < req.end_x);
            sy_next          = (req.start_y < req.end_y);
            count_next       = '0;
            drawn_next       = (req.req_type == lrfb_pkg::REQ_DRAW) && req_drawn;
            res_color_next   = '0;
            rd_in_frame_next = in_frame(req.start_x, req.start_y);
        end
        else if (state_reg == lrfb_pkg::ST_DRAW)
        begin
            plot_we_next   = plot;
            plot_addr_next = addr_of(x_reg, y_reg);
            plot_data_next = pen_reg;
            if (plot && (count_reg != lrfb_pkg::COUNT_MAX))
            begin
                count_next = count_reg + 1'b1;
            end
            if (!at_end)
            begin
                err_next = err_reg + (step_x ? dy_reg : '0) + (step_y ? dx_reg : '0);
                if (step_x)
                begin
                    x_next = sx_reg ? x_reg + 1'b1 : x_reg - 1'b1;
                end
                if (step_y)
                begin
                    y_next = sy_reg ? y_reg + 1'b1 : y_reg - 1'b1;
                end
            end
        end
        else if (state_reg == lrfb_pkg::ST_READ_DATA)
        begin
            res_color_next = rd_in_frame_reg ? mem_rd_data : '0;
        end
    end

    // response register
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (rsp_load)
        begin
            rsp_valid_next          = 1'b1;
            rsp_next.read_color     = res_color_reg;
            rsp_next.line_drawn     = drawn_reg;
            rsp_next.pixels_written = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrfb_pkg::ST_IDLE;
            plot_we_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            plot_we_reg   <= plot_we_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg           <= x_next;
        y_reg           <= y_next;
        xe_reg          <= xe_next;
        ye_reg          <= ye_next;
        pen_reg         <= pen_next;
        dx_reg          <= dx_next;
        dy_reg          <= dy_next;
        err_reg         <= err_next;
        sx_reg          <= sx_next;
        sy_reg          <= sy_next;
        count_reg       <= count_next;
        drawn_reg       <= drawn_next;
        res_color_reg   <= res_color_next;
        rd_in_frame_reg <= rd_in_frame_next;
        plot_addr_reg   <= plot_addr_next;
        plot_data_reg   <= plot_data_next;
        rsp_reg         <= rsp_next;
    end

    lrfb_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (plot_we_reg),
        .wr_addr (plot_addr_reg),
        .wr_data (plot_data_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (addr_of(x_reg, y_reg)),
        .rd_data (mem_rd_data),
        .busy    (store_busy)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    // no request enters during the zero-fill sweep
    a_no_take_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        store_busy |-> req_stall
    ) else $error("request accepted during framebuffer clear");

    // last pixel write has landed before a new request can start
    a_idle_no_pending_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == lrfb_pkg::ST_IDLE) |-> !plot_we_reg
    ) else $error("pixel write pending in idle");

    // a loaded response is never overwritten while stalled
    a_rsp_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |=> (rsp_valid_reg && $stable(rsp_reg))
    ) else $error("stalled response changed");

    // pixel writes only come out of the line walk
    a_write_from_draw: assert property (
        @(posedge clk) disable iff (!rst_n)
        plot_we_reg |-> ($past(state_reg) == lrfb_pkg::ST_DRAW)
    ) else $error("pixel write outside line walk");
`endif

endmodule

>>> tb/lrfb_frame_checker.sv
// ----------------------------------------------------------------------------
// lrfb_frame_checker
// Keeps a private copy of the framebuffer and the viewport. It walks each
// accepted draw and looks up each accepted read, then compares every response
// beat in order, field by field, against what it worked out.
// ----------------------------------------------------------------------------
module lrfb_frame_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_stall,
    input  lrfb_pkg::req_t              req,
    input  logic                        rsp_valid,
    input  logic                        rsp_stall,
    input  lrfb_pkg::rsp_t              rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [lrfb_pkg::APB_AW-1:0] paddr,
    input  logic [lrfb_pkg::APB_DW-1:0] pwdata,
    output int                          pending,
    output int                          mismatches,
    output int                          reads_seen,
    output int                          lines_drawn,
    output int                          lines_refused,
    output int                          pixel_total
);
    timeunit 1ns;
    timeprecision 1ps;

    import lrfb_pkg::*;

    localparam int FRAME_W      = FRAME_WIDTH_DEF;
    localparam int FRAME_H      = FRAME_HEIGHT_DEF;
    localparam int FRAME_PIXELS = FRAME_W * FRAME_H;

    color_t frame_image [FRAME_PIXELS];
    rsp_t   due_rsp [$];
    int     vp_left;
    int     vp_top;
    int     vp_right;
    int     vp_bottom;

    function automatic bit in_view(input int x, input int y);
        return x >= vp_left && x < vp_right && y >= vp_top && y < vp_bottom;
    endfunction

    function automatic bit on_frame(input int x, input int y);
        return x >= 0 && x < FRAME_W && y >= 0 && y < FRAME_H;
    endfunction

    // Bresenham error walk, endpoints inclusive; each pixel clipped again.
    task automatic render_request(input req_t r, output rsp_t e);
        int  x;
        int  y;
        int  x1;
        int  y1;
        int  dx;
        int  dy;
        int  sx;
        int  sy;
        int  err;
        int  e2;
        int  n;
        bit  done;
        e  = '0;
        x  = int'(r.start_x);
        y  = int'(r.start_y);
        x1 = int'(r.end_x);
        y1 = int'(r.end_y);
        if (r.req_type == REQ_READ) begin
            reads_seen++;
            if (on_frame(x, y))
                e.read_color = frame_image[y * FRAME_W + x];
        end
        else if (!(in_view(x, y) && in_view(x1, y1))) begin
            lines_refused++;
        end
        else begin
            dx   = (x1 >= x) ? x1 - x : x - x1;
            dy   = -((y1 >= y) ? y1 - y : y - y1);
            sx   = (x < x1) ? 1 : -1;
            sy   = (y < y1) ? 1 : -1;
            err  = dx + dy;
            n    = 0;
            done = 1'b0;
            while (!done) begin
                if (in_view(x, y) && on_frame(x, y)) begin
                    frame_image[y * FRAME_W + x] = r.pen_color;
                    n++;
                end
                if (x == x1 && y == y1) begin
                    done = 1'b1;
                end
                else begin
                    e2 = 2 * err;
                    if (e2 >= dy)
                    begin
                        err += dy;
                        x   += sx;
                    end
                    if (e2 <= dx)
                    begin
                        err += dx;
                        y   += sy;
                    end
                end
            end
            lines_drawn++;
            pixel_total += n;
            e.line_drawn     = 1'b1;
            e.pixels_written = (n > int'(COUNT_MAX)) ? COUNT_MAX : count_t'(n);
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        rsp_t due;
        rsp_t fresh;
        if (!rst_n) begin
            for (int a = 0; a < FRAME_PIXELS; a++)
                frame_image[a] = '0;
            due_rsp.delete();
            vp_left       = int'(LEFT_RST);
            vp_top        = int'(TOP_RST);
            vp_right      = int'(RIGHT_RST);
            vp_bottom     = int'(BOTTOM_RST);
            mismatches    = 0;
            reads_seen    = 0;
            lines_drawn   = 0;
            lines_refused = 0;
            pixel_total   = 0;
            pending      <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_AW-1:2])
                    REG_LEFT:   vp_left   = int'(pwdata[COORD_W-1:0]);
                    REG_TOP:    vp_top    = int'(pwdata[COORD_W-1:0]);
                    REG_RIGHT:  vp_right  = int'(pwdata[COORD_W-1:0]);
                    REG_BOTTOM: vp_bottom = int'(pwdata[COORD_W-1:0]);
                    default:    ;
                endcase
            end
            if (rsp_valid && !rsp_stall) begin
                if (due_rsp.size() == 0) begin
                    $display("%0t: response beat with nothing expected, actual %0d/%0d/%0d",
                             $time, rsp.read_color, rsp.line_drawn, rsp.pixels_written);
                    mismatches++;
                end
                else begin
                    due = due_rsp.pop_front();
                    compare_field("read_color", due.read_color, rsp.read_color);
                    compare_field("line_drawn", due.line_drawn, rsp.line_drawn);
                    compare_field("pixels_written", due.pixels_written, rsp.pixels_written);
                end
            end
            if (req_valid && !req_stall) begin
                render_request(req, fresh);
                due_rsp.push_back(fresh);
            end
            pending <= due_rsp.size();
        end
    end

endmodule

>>> tb/line_rasterizer_framebuffer_top_tb.sv
// ----------------------------------------------------------------------------
// line_rasterizer_framebuffer_top_tb
// Drives draw and read beats through the line engine under a series of
// viewport settings (default, narrow, empty, inverted, beyond the frame,
// outside the frame), with random idling on both channels. The frame checker
// predicts and compares every response; this module gives the verdict.
// ----------------------------------------------------------------------------
module line_rasterizer_framebuffer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrfb_pkg::*;

    // clear sweep after reset is the longest quiet stretch;
    // the limit sits a few times above it
    localparam int BEAT_TIMEOUT = 1000000;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    req_t               req_beat;
    logic               rsp_valid;
    logic               rsp_stall;
    rsp_t               rsp_beat;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    int idle_odds = 0;
    int vp_left;
    int vp_top;
    int vp_right;
    int vp_bottom;
    int line_x0;
    int line_y0;
    int line_x1;
    int line_y1;
    int pending;
    int mismatches;
    int reads_seen;
    int lines_drawn;
    int lines_refused;
    int pixel_total;

    line_rasterizer_framebuffer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req_beat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_beat),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    lrfb_frame_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req_beat),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp_beat),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pending       (pending),
        .mismatches    (mismatches),
        .reads_seen    (reads_seen),
        .lines_drawn   (lines_drawn),
        .lines_refused (lines_refused),
        .pixel_total   (pixel_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // response-side stall bursts
    initial
    begin
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            rsp_stall <= 1'b0;
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < BEAT_TIMEOUT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no beat for %0d cycles, pending %0d", $time, BEAT_TIMEOUT, pending);
        $display("Test completed with failures");
        $finish;
    end

    function automatic int view_coord(input int lo, input int hi);
        if (hi > lo)
            return $urandom_range(lo, hi - 1);
        return $urandom_range(0, 1023);
    endfunction

    function automatic int clamp_into(input int v, input int lo, input int hi);
        if (hi <= lo)
            return v & 1023;
        if (v < lo)
            return lo;
        if (v >= hi)
            return hi - 1;
        return v;
    endfunction

    task automatic issue(input req_t r);
        req_valid <= 1'b1;
        req_beat  <= r;
        do @(posedge clk); while (req_stall);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic draw(input int x0, input int y0, input int x1, input int y1,
                        input int color);
        req_t r;
        r.req_type  = REQ_DRAW;
        r.start_x   = coord_t'(x0);
        r.start_y   = coord_t'(y0);
        r.end_x     = coord_t'(x1);
        r.end_y     = coord_t'(y1);
        r.pen_color = color_t'(color);
        line_x0 = x0;
        line_y0 = y0;
        line_x1 = x1;
        line_y1 = y1;
        issue(r);
    endtask

    task automatic read_at(input int x, input int y);
        req_t r;
        r.req_type  = REQ_READ;
        r.start_x   = coord_t'(x);
        r.start_y   = coord_t'(y);
        r.end_x     = coord_t'($urandom);
        r.end_y     = coord_t'($urandom);
        r.pen_color = color_t'($urandom);
        issue(r);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_viewport(input int l, input int t, input int r, input int b);
        drain();
        apb_write(REG_LEFT, l);
        apb_write(REG_TOP, t);
        apb_write(REG_RIGHT, r);
        apb_write(REG_BOTTOM, b);
        vp_left   = l;
        vp_top    = t;
        vp_right  = r;
        vp_bottom = b;
    endtask

    // mostly short in-view lines and reads along recent lines, some noise
    task automatic run_phase(input int count, input int odds);
        req_t        r;
        logic [63:0] noise;
        int          roll;
        int          x0;
        int          y0;
        idle_odds = odds;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                x0 = view_coord(vp_left, vp_right);
                y0 = view_coord(vp_top, vp_bottom);
                draw(x0, y0,
                     clamp_into(x0 + int'($urandom_range(0, 24)) - 12, vp_left, vp_right),
                     clamp_into(y0 + int'($urandom_range(0, 24)) - 12, vp_top, vp_bottom),
                     $urandom_range(0, 255));
            end
            else if (roll < 62) begin
                draw(view_coord(vp_left, vp_right), view_coord(vp_top, vp_bottom),
                     view_coord(vp_left, vp_right), view_coord(vp_top, vp_bottom),
                     $urandom_range(0, 255));
            end
            else if (roll < 88) begin
                case ($urandom_range(0, 3))
                    0:       read_at(line_x0, line_y0);
                    1:       read_at(line_x1, line_y1);
                    2:       read_at((line_x0 + line_x1) / 2, (line_y0 + line_y1) / 2);
                    default: read_at($urandom_range(0, 511), $urandom_range(0, 511));
                endcase
            end
            else begin
                noise = {$urandom(), $urandom()};
                r     = noise[$bits(req_t)-1:0];
                issue(r);
            end
            if ($urandom_range(0, 149) == 0)
                drain();
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_beat  <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        vp_left   = int'(LEFT_RST);
        vp_top    = int'(TOP_RST);
        vp_right  = int'(RIGHT_RST);
        vp_bottom = int'(BOTTOM_RST);
        line_x0   = 0;
        line_y0   = 0;
        line_x1   = 0;
        line_y1   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: corners, full spans, both directions, rejects, reads
        read_at(0, 0);
        draw(0, 0, 0, 0, 8'hFF);
        read_at(0, 0);
        draw(0, 5, 511, 5, 8'hAA);
        draw(511, 511, 511, 0, 8'h55);
        draw(0, 511, 511, 0, 8'h0F);
        draw(10, 20, 13, 400, 8'h33);
        draw(300, 100, 20, 110, 8'hC3);
        draw(0, 0, 512, 3, 8'h77);
        draw(1023, 1023, 0, 0, 8'h01);
        draw(0, 0, 1023, 1023, 8'h11);
        draw(200, 300, 200, 300, 8'h00);
        read_at(511, 5);
        read_at(1023, 1023);
        read_at(256, 255);
        read_at(12, 210);
        read_at(512, 0);
        read_at(0, 512);
        read_at(200, 300);
        read_at(100, 104);
        run_phase(162, 4);

        set_viewport(100, 50, 200, 180);
        draw(100, 50, 199, 179, 8'h5A);
        draw(99, 60, 150, 60, 8'h5B);
        run_phase(180, 3);

        set_viewport(300, 300, 300, 300);
        draw(300, 300, 300, 300, 8'h22);
        run_phase(40, 5);

        set_viewport(400, 0, 100, 512);
        run_phase(30, 4);

        // window larger than the frame: off-frame pixels are not written
        set_viewport(0, 0, 1023, 1023);
        draw(500, 500, 1000, 520, 8'h44);
        draw(1022, 0, 0, 1022, 8'h66);
        read_at(511, 511);
        read_at(600, 600);
        run_phase(60, 4);

        set_viewport(7, 0, 8, 512);
        run_phase(70, 3);

        set_viewport(512, 512, 1023, 1023);
        draw(512, 512, 700, 900, 8'h99);
        run_phase(30, 4);

        set_viewport(0, 0, 0, 0);
        run_phase(20, 4);

        set_viewport(0, 0, 512, 512);
        run_phase(230, 0);
        run_phase(220, 3);
        run_phase(100, 0);

        drain();
        repeat (16) @(posedge clk);

        $display("Covered %0d reads and %0d line requests (%0d drawn, %0d refused)",
                 reads_seen, lines_drawn + lines_refused, lines_drawn, lines_refused);
        $display("%0d pixels written across nine viewport settings", pixel_total);
        if (mismatches == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
rtl/lrfb_pkg.sv
rtl/lrfb_store.sv
rtl/line_rasterizer_framebuffer_top.sv
tb/lrfb_frame_checker.sv
tb/line_rasterizer_framebuffer_top_tb.sv
